// File: hw/rtl/lxd_pkg.sv
// shared types and constants of the length/xor packet deframer
package lxd_pkg;

  localparam int unsigned LenW  = 16;
  localparam int unsigned ByteW = 8;

  localparam logic [LenW-1:0] HeaderBytes  = 16'd3;
  localparam logic [LenW-1:0] MaxLenReset  = 16'd1024;

  // verdict codes carried on the last beat of a frame
  localparam logic [1:0] StGood   = 2'd0;
  localparam logic [1:0] StSumErr = 2'd1;
  localparam logic [1:0] StOver   = 2'd2;
  localparam logic [1:0] StBadLen = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             data_valid;
    logic             last;
    logic [1:0]       status;
  } lxd_result_t;

  // parser to output buffer: one result beat and its push strobe
  typedef struct packed {
    logic        push;
    lxd_result_t res;
  } lxd_push_t;

endpackage

// File: hw/rtl/lxd_byte_if.sv
// valid/ready channel carrying one received stream byte per beat
interface lxd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// File: hw/rtl/lxd_result_if.sv
// valid/ready channel carrying one deframed result per beat
interface lxd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       data_valid;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output data, output data_valid, output last,
                  output status, input ready);
  modport sink (input valid, input data, input data_valid, input last,
                input status, output ready);
endinterface

// File: hw/rtl/lxd_parser.sv
// frame parser: header decode, running xor, byte countdown and verdict
module lxd_parser import lxd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LenW-1:0]  cfg_wdata_i,
  input  logic             accept_i,
  input  logic [ByteW-1:0] byte_i,
  output lxd_push_t        push_o
);

  localparam logic [1:0] PhLenLo = 2'd0;
  localparam logic [1:0] PhLenHi = 2'd1;
  localparam logic [1:0] PhSum   = 2'd2;
  localparam logic [1:0] PhData  = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [ByteW-1:0] len_lo_q, len_lo_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [ByteW-1:0] exp_sum_q, exp_sum_d;
  logic [ByteW-1:0] run_sum_q, run_sum_d;
  logic             skip_q, skip_d;
  logic [LenW-1:0]  max_len_q;

  logic [LenW-1:0]  total;
  logic [ByteW-1:0] sum_next;
  logic [LenW-1:0]  left_dec;

  assign total    = {byte_i, len_lo_q};
  assign sum_next = run_sum_q ^ byte_i;
  assign left_dec = left_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    len_lo_d  = len_lo_q;
    left_d    = left_q;
    exp_sum_d = exp_sum_q;
    run_sum_d = run_sum_q;
    skip_d    = skip_q;
    push_o    = '0;
    if (accept_i) begin
      case (phase_q)
        PhLenLo: begin
          len_lo_d = byte_i;
          phase_d  = PhLenHi;
        end
        PhLenHi: begin
          if (total < HeaderBytes) begin
            phase_d           = PhLenLo;
            push_o.push       = 1'b1;
            push_o.res.last   = 1'b1;
            push_o.res.status = StBadLen;
          end else begin
            left_d    = total - HeaderBytes;
            skip_d    = (total > max_len_q);
            run_sum_d = '0;
            phase_d   = PhSum;
          end
        end
        PhSum: begin
          exp_sum_d = byte_i;
          run_sum_d = '0;
          if (left_q == '0) begin
            // empty payload ends the frame at the checksum byte
            phase_d           = PhLenLo;
            push_o.push       = 1'b1;
            push_o.res.last   = 1'b1;
            push_o.res.status = skip_q ? StOver :
                                ((byte_i == '0) ? StGood : StSumErr);
          end else begin
            phase_d = PhData;
          end
        end
        default: begin
          run_sum_d = sum_next;
          left_d    = left_dec;
          if (left_dec == '0) begin
            phase_d         = PhLenLo;
            push_o.push     = 1'b1;
            push_o.res.last = 1'b1;
            if (skip_q) begin
              push_o.res.status = StOver;
            end else begin
              push_o.res.data       = byte_i;
              push_o.res.data_valid = 1'b1;
              push_o.res.status     = (sum_next == exp_sum_q) ? StGood : StSumErr;
            end
          end else if (!skip_q) begin
            push_o.push           = 1'b1;
            push_o.res.data       = byte_i;
            push_o.res.data_valid = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLenLo;
      len_lo_q  <= '0;
      left_q    <= '0;
      exp_sum_q <= '0;
      run_sum_q <= '0;
      skip_q    <= 1'b0;
      max_len_q <= MaxLenReset;
    end else begin
      phase_q   <= phase_d;
      len_lo_q  <= len_lo_d;
      left_q    <= left_d;
      exp_sum_q <= exp_sum_d;
      run_sum_q <= run_sum_d;
      skip_q    <= skip_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // payload phase always has at least one byte still to come
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> left_q != '0)
    else $error("payload phase with zero bytes left");

  // bad length verdict only comes from the high length byte
  a_badlen_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push && push_o.res.status == StBadLen |-> phase_q == PhLenHi)
    else $error("bad length verdict outside length decode");

  // skipped frames never pass payload on
  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push && phase_q == PhData && skip_q |-> !push_o.res.data_valid)
    else $error("payload passed on while skipping");

endmodule

// File: hw/rtl/lxd_out_buf.sv
// two-entry output register with skid slot between parser and receiver
module lxd_out_buf import lxd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lxd_push_t push_i,
  output logic      in_ready_o,
  lxd_result_if.source res_o
);

  logic        main_v_q;
  logic        skid_v_q;
  lxd_result_t main_q;
  lxd_result_t skid_q;
  logic        pop;

  assign pop        = main_v_q && res_o.ready;
  assign in_ready_o = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i.push;
      end
    end else if (push_i.push) begin
      if (!main_v_q) begin
        main_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (push_i.push) begin
        main_q <= push_i.res;
      end
    end else if (push_i.push) begin
      if (!main_v_q) begin
        main_q <= push_i.res;
      end else begin
        skid_q <= push_i.res;
      end
    end
  end

  assign res_o.valid      = main_v_q;
  assign res_o.data       = main_q.data;
  assign res_o.data_valid = main_q.data_valid;
  assign res_o.last       = main_q.last;
  assign res_o.status     = main_q.status;

  // skid slot only fills behind a held main entry
  a_skid_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid slot full with empty main entry");

  // nothing may be pushed into a full buffer
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> !skid_v_q)
    else $error("result pushed into full output buffer");

  // a stalled skid entry moves to the head on the next pop
  a_skid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && pop |=> main_v_q && !skid_v_q)
    else $error("skid entry lost on pop");

endmodule

// File: hw/rtl/length_xor_packet_deframer_core.sv
// top level of the length-prefixed frame deframer with xor checksum
//
// in_i carries the framed byte stream, one byte per beat: a 16-bit
// little-endian total length (header included), a checksum byte, then the
// payload. res_o gives one beat per payload byte, with a running xor kept
// over the payload; the beat that ends a frame has last set and a verdict
// in status (good, checksum error, oversize, bad length). oversize frames
// pass no payload and are flagged once at their end; lengths below three
// are flagged at the high length byte and parsing restarts with the next.
// cfg_we_i/cfg_wdata_i write max_length; the user must write it only while
// the block is idle, as the block does not enforce this. a byte is taken
// every cycle while in_i.ready is high; its result is registered before res_o.
// the output has a main register and a skid slot, so in_i keeps flowing
// while one result waits; ready drops only once both slots hold results.
// reset clears the parser to expect a length low byte, empties the output
// and sets max_length to 1024; there is no clearing pass.
module length_xor_packet_deframer_core import lxd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  lxd_byte_if.sink        in_i,
  lxd_result_if.source    res_o
);

  lxd_push_t push;
  logic      buf_ready;
  logic      accept;

  // a byte beat is taken whenever the skid slot is free
  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  lxd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (in_i.in_byte),
    .push_o      (push)
  );

  // result register plus skid slot toward the receiver
  lxd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_ready_o (buf_ready),
    .res_o      (res_o)
  );

endmodule

// File: sim/lxd_frame_checker.sv
// checker for the length/xor deframer: predicts result beats and compares them
`timescale 1ns / 1ps
module lxd_frame_checker import lxd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  lxd_byte_if             in_mon,
  lxd_result_if           res_mon,
  output int unsigned     err_cnt_o,
  output int unsigned     pending_o
);

  typedef enum logic [1:0] {PhLenLo, PhLenHi, PhSum, PhData} parse_phase_e;

  parse_phase_e    phase_q;
  logic [7:0]      len_lo_q;
  logic [7:0]      sum_q;
  logic [7:0]      xor_q;
  logic [LenW-1:0] left_q;
  logic [LenW-1:0] max_len_q;
  logic            skip_q;
  lxd_result_t     result_q[$];
  int unsigned     err_cnt = 0;
  int unsigned     pending_cnt = 0;

  assign err_cnt_o = err_cnt;
  assign pending_o = pending_cnt;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < 50) begin
      $display("%0t lxd_frame_checker: %s got %0h expected %0h", $time, what, got, want);
    end
    err_cnt++;
  endtask

  function automatic logic [1:0] frame_verdict();
    if (skip_q) return StOver;
    return (xor_q == sum_q) ? StGood : StSumErr;
  endfunction

  // advances the parser copy by one stream byte, queues the beat it causes
  task automatic deframe_byte(input logic [7:0] b);
    lxd_result_t     r;
    logic [LenW-1:0] total;
    logic            has_res;
    r = '0;
    has_res = 1'b0;
    case (phase_q)
      PhLenLo: begin
        len_lo_q = b;
        phase_q = PhLenHi;
      end
      PhLenHi: begin
        total = {b, len_lo_q};
        if (total < HeaderBytes) begin
          phase_q = PhLenLo;
          r.last = 1'b1;
          r.status = StBadLen;
          has_res = 1'b1;
        end else begin
          left_q = total - HeaderBytes;
          skip_q = total > max_len_q;
          xor_q = 8'h00;
          phase_q = PhSum;
        end
      end
      PhSum: begin
        sum_q = b;
        xor_q = 8'h00;
        if (left_q == '0) begin
          phase_q = PhLenLo;
          r.last = 1'b1;
          r.status = frame_verdict();
          has_res = 1'b1;
        end else begin
          phase_q = PhData;
        end
      end
      default: begin
        xor_q = xor_q ^ b;
        left_q = left_q - 16'd1;
        if (left_q == '0) begin
          phase_q = PhLenLo;
          has_res = 1'b1;
          r.last = 1'b1;
          r.status = frame_verdict();
          if (!skip_q) begin
            r.data = b;
            r.data_valid = 1'b1;
          end
        end else if (!skip_q) begin
          has_res = 1'b1;
          r.data = b;
          r.data_valid = 1'b1;
        end
      end
    endcase
    if (has_res) result_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lxd_result_t want;
    if (!rst_ni) begin
      phase_q = PhLenLo;
      len_lo_q = 8'h00;
      sum_q = 8'h00;
      xor_q = 8'h00;
      left_q = '0;
      skip_q = 1'b0;
      max_len_q = MaxLenReset;
      result_q.delete();
      pending_cnt = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("beat with nothing expected, data", res_mon.data, 0);
        end else begin
          want = result_q.pop_front();
          if (res_mon.data !== want.data)
            report_mismatch("data", res_mon.data, want.data);
          if (res_mon.data_valid !== want.data_valid)
            report_mismatch("data_valid", res_mon.data_valid, want.data_valid);
          if (res_mon.last !== want.last)
            report_mismatch("last", res_mon.last, want.last);
          if (res_mon.status !== want.status)
            report_mismatch("status", res_mon.status, want.status);
        end
      end
      if (in_mon.valid && in_mon.ready) deframe_byte(in_mon.in_byte);
      if (cfg_we_i) max_len_q = cfg_wdata_i;
      pending_cnt = result_q.size();
    end
  end

endmodule

// File: sim/tb.sv
// testbench top: drives framed byte streams and max_length writes, gives the verdict
`timescale 1ns / 1ps
module tb;
  import lxd_pkg::*;

  // generous bound: ~650 beats, each with a sender gap and a slow receiver,
  // plus one long receiver hold-off, taken many times over
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [LenW-1:0] cfg_wdata;

  int unsigned     err_cnt;
  int unsigned     pending;
  int unsigned     cycle_cnt = 0;
  int unsigned     burst_left = 0;
  int unsigned     bytes_sent = 0;
  logic [LenW-1:0] cur_max = MaxLenReset;
  logic            hold_req = 1'b0;
  logic            hold_done = 1'b0;
  logic [7:0]      script_q[$];

  lxd_byte_if   in_if ();
  lxd_result_if res_if ();

  length_xor_packet_deframer_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .res_o       (res_if)
  );

  lxd_frame_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_mon      (in_if),
    .res_mon     (res_if),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog: a hung handshake or a lost beat ends here
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: switches at random between four stall patterns; once asked, it
  // holds ready low for a long stretch so both output slots fill and the block
  // has to stall its input
  initial begin : rx_stall
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_cnt;
    int unsigned rx_tick;
    mode = RxOpen;
    mode_left = 0;
    hold_cnt = 0;
    rx_tick = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt == HoldCycles) hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          RxOpen:   res_if.ready <= 1'b1;
          RxCoin:   res_if.ready <= 1'($urandom_range(0, 1));
          RxSparse: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:  res_if.ready <= ((rx_tick % 5) != 0);
        endcase
      end
    end
  end

  // one beat on the input; bursts of random length with random gaps between
  // them, and about a third of the bursts follow on with no gap at all
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    bytes_sent++;
  endtask

  // length low, length high, then (for a legal length) checksum and payload
  task automatic send_frame(input logic [LenW-1:0] total, input bit good_sum);
    logic [7:0] payload[$];
    logic [7:0] sum;
    sum = 8'h00;
    send_byte(total[7:0]);
    send_byte(total[15:8]);
    if (total >= HeaderBytes) begin
      repeat (int'(total - HeaderBytes)) begin
        payload.push_back(8'($urandom));
        sum = sum ^ payload[$];
      end
      if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(sum);
      foreach (payload[i]) send_byte(payload[i]);
    end
  endtask

  // mostly well-formed short frames with random content; some bad lengths
  // and lengths right at the max_length boundary
  task automatic send_random_frame();
    int unsigned     pick;
    logic [LenW-1:0] total;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      total = LenW'($urandom_range(0, 2));
    end else if (pick < 18 && cur_max < 60) begin
      total = cur_max + LenW'($urandom_range(0, 1));
    end else begin
      total = LenW'($urandom_range(3, 27));
    end
    send_frame(total, $urandom_range(0, 3) != 0);
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_frame();
  endtask

  // drop valid, drain all expected beats, then let the parser register and
  // skid slot settle before touching max_length
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LenW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_max = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // max_length at reset value
    script_q = '{
      8'h00, 8'h00,                      // bad length, total zero
      8'h01, 8'h00,                      // bad length, total one
      8'h02, 8'h00,                      // bad length, total two
      8'h03, 8'h00, 8'h00,               // empty payload, checksum good
      8'h03, 8'h00, 8'h5A,               // empty payload, checksum error
      8'h05, 8'h00, 8'hFF, 8'hFF, 8'h00, // two payload beats, all-ones and zero
      8'h04, 8'h00, 8'h00, 8'hA5         // one payload beat, checksum error
    };
    foreach (script_q[i]) send_byte(script_q[i]);
    // one long frame with a nonzero high length byte
    send_frame(16'd259, 1'b1);
    run_phase(50);
    settle();

    // largest max_length
    write_max_len(16'hFFFF);
    run_phase(45);
    settle();

    // smallest legal max_length: any payload makes the frame oversize
    write_max_len(HeaderBytes);
    script_q = '{
      8'h04, 8'h00, 8'hAA, 8'h55,        // oversize, flagged on its one payload beat
      8'h03, 8'h00, 8'h07                // exactly max_length, checksum error
    };
    foreach (script_q[i]) send_byte(script_q[i]);
    run_phase(35);
    settle();

    // max_length below the header size: every legal frame is oversize
    write_max_len('0);
    script_q = '{8'h03, 8'h00, 8'h00};   // oversize with empty payload
    foreach (script_q[i]) send_byte(script_q[i]);
    run_phase(25);
    settle();

    write_max_len(16'd2);
    run_phase(20);
    settle();

    // random small max_length, with the long receiver hold-off in this phase
    write_max_len(LenW'($urandom_range(4, 40)));
    hold_req = 1'b1;
    run_phase(85);
    settle();

    // back to the reset value
    write_max_len(MaxLenReset);
    run_phase(40);
    settle();

    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lxd_pkg.sv
hw/rtl/lxd_byte_if.sv
hw/rtl/lxd_result_if.sv
hw/rtl/lxd_parser.sv
hw/rtl/lxd_out_buf.sv
hw/rtl/length_xor_packet_deframer_core.sv
sim/lxd_frame_checker.sv
sim/tb.sv
